FILE: rtl/bft_pkg.sv
// ---------------------------------------------------------------------------
// Flow table package
// Shared types and status codes of the bidirectional flow table.
// ---------------------------------------------------------------------------
package bft_pkg;

  // Result status codes.
  localparam logic [1:0] StMatch       = 2'd0;
  localparam logic [1:0] StNew         = 2'd1;
  localparam logic [1:0] StUnsupported = 2'd2;
  localparam logic [1:0] StFull        = 2'd3;

  // Transport kinds on the input.
  localparam logic [1:0] ProtoUdp = 2'd1;
  localparam logic [1:0] ProtoTcp = 2'd2;

  // Classified request passed from the front part to the back part.
  typedef struct packed {
    logic        supported;
    logic        tcp;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_src;
    logic [15:0] l4_dst;
  } req_t;

  // Stored flow key.
  typedef struct packed {
    logic        tcp;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] l4_src;
    logic [15:0] l4_dst;
  } key_t;

endpackage

FILE: rtl/bft_front.sv
// ---------------------------------------------------------------------------
// Flow table front part
// Accepts packet headers, classifies them and queues them for the search.
// ---------------------------------------------------------------------------
module bft_front
  import bft_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [1:0] proto_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] src_l4_port_i,
  input  logic [15:0] dst_l4_port_i,
  output logic       req_valid_o,
  input  logic       req_take_i,
  output req_t       req_o
);

  // Two-entry queue.
  req_t       q_mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;
  req_t       req_in;

  assign stall_o     = (fill_q == 2'd2);
  assign push        = valid_i && !stall_o;
  assign req_valid_o = (fill_q != 2'd0);
  assign pop         = req_valid_o && req_take_i;
  assign req_o       = q_mem_q[rd_ptr_q];

  // Classification of the transport kind.
  always_comb begin
    req_in.supported = (proto_i == ProtoUdp) || (proto_i == ProtoTcp);
    req_in.tcp       = (proto_i == ProtoTcp);
    req_in.src_ip    = src_ip_i;
    req_in.dst_ip    = dst_ip_i;
    req_in.l4_src    = src_l4_port_i;
    req_in.l4_dst    = dst_l4_port_i;
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= req_in;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q != 2'd3) else $error("queue fill out of range");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q == 2'd0 |-> !pop) else $error("pop from empty queue");
  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> fill_q == $past(fill_q) + 2'd1) else $error("fill lost");
`endif

endmodule

FILE: rtl/bft_back.sv
// ---------------------------------------------------------------------------
// Flow table back part
// Searches the table one slot at a time, then counts or creates the flow or reports the table full.
// ---------------------------------------------------------------------------
module bft_back
  import bft_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_take_o,
  input  req_t        req_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  status_o,
  output logic [6:0]  slot_o,
  output logic [31:0] packet_count_o,
  output logic [7:0]  flow_total_o
);

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  // Table storage; keys and counts live in memories.
  key_t        key_mem   [TABLE_DEPTH];
  logic [31:0] count_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] used_q;

  logic [2:0]      state_q;
  req_t            cur_q;
  logic [IdxW-1:0] idx_q;
  logic            rd_used_q;
  key_t            rd_key_q;
  logic [31:0]     rd_cnt_q;
  logic            free_found_q;
  logic [IdxW-1:0] free_idx_q;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  logic [7:0]      flows_q;
  logic [CntW-1:0] scan_q;

  logic            out_valid_q;
  logic [1:0]      status_q;
  logic [6:0]      slot_q;
  logic [31:0]     count_q;

  logic match_fwd, match_rev, match;
  logic wr_en;
  logic [IdxW-1:0] wr_idx;
  key_t  wr_key;
  logic [31:0] wr_cnt;

  assign req_take_o     = (state_q == S_IDLE) && req_valid_i && !out_valid_q;
  assign valid_o        = out_valid_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;
  assign packet_count_o = count_q;
  assign flow_total_o   = flows_q;

  // Compare the registered entry both ways.
  always_comb begin
    match_fwd = (rd_key_q.src_ip == cur_q.src_ip) && (rd_key_q.dst_ip == cur_q.dst_ip) &&
                (rd_key_q.l4_src == cur_q.l4_src) &&
                (rd_key_q.l4_dst == cur_q.l4_dst);
    match_rev = (rd_key_q.src_ip == cur_q.dst_ip) && (rd_key_q.dst_ip == cur_q.src_ip) &&
                (rd_key_q.l4_src == cur_q.l4_dst) &&
                (rd_key_q.l4_dst == cur_q.l4_src);
    match     = rd_used_q && (rd_key_q.tcp == cur_q.tcp) && (match_fwd || match_rev);
  end

  // Memory write port.
  always_comb begin
    wr_en  = (state_q == S_UPDATE) && (hit_q || free_found_q);
    wr_idx = hit_q ? hit_idx_q : free_idx_q;
    wr_key.tcp    = cur_q.tcp;
    wr_key.src_ip = cur_q.src_ip;
    wr_key.dst_ip = cur_q.dst_ip;
    wr_key.l4_src = cur_q.l4_src;
    wr_key.l4_dst = cur_q.l4_dst;
    wr_cnt = hit_q ? ((rd_cnt_q == 32'hFFFF_FFFF) ? rd_cnt_q : rd_cnt_q + 32'd1) : 32'd1;
  end

  // Memory access: one registered read, one write.
  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[idx_q];
    rd_cnt_q <= count_mem[idx_q];
    if (wr_en) begin
      count_mem[wr_idx] <= wr_cnt;
      if (!hit_q) key_mem[wr_idx] <= wr_key;
    end
  end

  // Request holding register.
  always_ff @(posedge clk_i) begin
    if (req_take_o) cur_q <= req_i;
  end

  // Search sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      rd_used_q    <= 1'b0;
      used_q       <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      hit_q        <= 1'b0;
      hit_idx_q    <= '0;
      flows_q      <= '0;
      scan_q       <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= StMatch;
      slot_q       <= '0;
      count_q      <= '0;
    end else begin
      if (out_valid_q && !stall_i && (state_q != S_OUT)) out_valid_q <= 1'b0;
      rd_used_q <= used_q[idx_q];
      unique case (state_q)
        S_IDLE: begin
          if (req_take_o) begin
            idx_q        <= '0;
            scan_q       <= '0;
            free_found_q <= 1'b0;
            hit_q        <= 1'b0;
            state_q      <= req_i.supported ? S_READ : S_OUT;
          end
        end
        S_READ: begin
          // Address presented; data arrives next cycle.
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (!rd_used_q && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= idx_q;
          end
          if (match) begin
            hit_q     <= 1'b1;
            hit_idx_q <= idx_q;
            state_q   <= S_UPDATE;
          end else if (idx_q == LastIdx) begin
            state_q <= S_UPDATE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            scan_q  <= scan_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_UPDATE: begin
          if (!hit_q && free_found_q) begin
            used_q[free_idx_q] <= 1'b1;
            if (flows_q != 8'hFF) flows_q <= flows_q + 8'd1;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (!cur_q.supported) begin
              status_q <= StUnsupported;
              slot_q   <= '0;
              count_q  <= '0;
            end else if (hit_q) begin
              status_q <= StMatch;
              slot_q   <= 7'(hit_idx_q);
              count_q  <= wr_cnt;
            end else if (free_found_q) begin
              status_q <= StNew;
              slot_q   <= 7'(free_idx_q);
              count_q  <= 32'd1;
            end else begin
              status_q <= StFull;
              slot_q   <= '0;
              count_q  <= '0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_q <= CntW'(TABLE_DEPTH)) else $error("scan past table end");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && stall_i |=> out_valid_q && $stable(status_q)) else $error("result lost");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take_o |-> state_q == S_IDLE) else $error("take while busy");
  a_flows_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flows_q >= $past(flows_q)) else $error("flow total fell");
`endif

endmodule

FILE: rtl/bidirectional_flow_table_unit.sv
// ---------------------------------------------------------------------------
// Bidirectional flow table
// Five-tuple connection tracking with packet counts per flow.
// ---------------------------------------------------------------------------
// Usage: a request is a packet header (proto, addresses, ports) on the
// input channel, taken when valid_i is high and stall_o is low. Each
// request yields exactly one result on the output channel: status, slot,
// saturating packet count and the number of flows made since reset.
// A front part classifies requests into a two-deep queue; the back part
// searches the table one slot at a time through a registered read, with a
// read state and a check state per slot. A search ends at the first hit
// or after the last slot, and an unsupported request skips it. The next
// request starts once the result is taken. Reset empties the table at
// once through per-slot used bits and clears the flow total. While
// stall_i is high a result holds on the outputs; the back part waits and
// the queue still takes up to two requests.
// ---------------------------------------------------------------------------
module bidirectional_flow_table_unit
  import bft_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [1:0]  proto_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] src_l4_port_i,
  input  logic [15:0] dst_l4_port_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  status_o,
  output logic [6:0]  slot_o,
  output logic [31:0] packet_count_o,
  output logic [7:0]  flow_total_o
);

  logic req_valid, req_take;
  req_t req;

  // Front part: acceptance and classification.
  bft_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .proto_i, .src_ip_i, .dst_ip_i,
    .src_l4_port_i, .dst_l4_port_i,
    .req_valid_o (req_valid),
    .req_take_i  (req_take),
    .req_o       (req)
  );

  // Back part: table search and update.
  bft_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .req_valid_i (req_valid),
    .req_take_o  (req_take),
    .req_i       (req),
    .valid_o, .stall_i, .status_o, .slot_o, .packet_count_o, .flow_total_o
  );

endmodule
